[design/wra_pkg.sv]
// ----------------------------------------------------------------------------
// Wrapping register ALU package
// Operation codes, sequencer states, widths and the result wrap function.
// ----------------------------------------------------------------------------
`default_nettype none

package wra_pkg;

  localparam int unsigned AccW     = 32;
  localparam int unsigned WidthW   = 6;
  localparam int unsigned MaxWidth = 32;
  localparam int unsigned CntW     = $clog2(AccW);
  localparam int unsigned AddW     = AccW + 2;
  localparam int unsigned ShW      = $clog2(AccW);

  typedef enum logic [2:0] {
    MODE_LOAD = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4,
    MODE_MOD  = 3'd5,
    MODE_MIN  = 3'd6,
    MODE_MAX  = 3'd7
  } mode_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_ABSB = 6'b000100,
    ST_ITER = 6'b001000,
    ST_FIX  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  // Clamp width to 1..min(MaxWidth, AccW), then wrap and sign extend.
  function automatic logic [AccW-1:0] wrap_value(input logic [AccW-1:0] value,
                                                 input logic [WidthW-1:0] width);
    logic [WidthW-1:0] w;
    logic [ShW-1:0]    sh;
    logic [AccW-1:0]   up;
    w = width;
    if (w == '0) begin
      w = WidthW'(1);
    end
    if (w > WidthW'((MaxWidth < AccW) ? MaxWidth : AccW)) begin
      w = WidthW'((MaxWidth < AccW) ? MaxWidth : AccW);
    end
    sh = ShW'(WidthW'(AccW) - w);
    up = value << sh;
    return AccW'($signed(up) >>> sh);
  endfunction

endpackage

`default_nettype wire

[design/wrapping_register_alu_core.sv]
// ----------------------------------------------------------------------------
// Wrapping register ALU core
// Signed accumulator with load/add/sub/mul/div/mod/min/max, wrapped to a
// programmable register width.
// ----------------------------------------------------------------------------
// One item is worked at a time on a single shared 34-bit adder/subtractor
// driven by a small sequencer; in_ready_o is low while an item is in flight.
// Load, add, sub, min, max and any div or mod by zero pass through an execute
// state and an output state; mul iterates one shift-add step per operand bit;
// div and mod remove the signs, run one restoring step per bit, then fix the
// signs. The output state waits while a previous result is still held on the
// output. The user is to write reg_width only while idle; the block itself
// does not enforce it. 0 acts as 1 and values above 32 act as 32.
`default_nettype none

module wrapping_register_alu_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [wra_pkg::WidthW-1:0]  cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire [2:0]                  mode_i,
  input  wire signed [31:0]          operand_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic signed [31:0]         result_value_o
);
  import wra_pkg::*;

  state_e              state_q, state_d;
  mode_e               mode_q;
  logic [WidthW-1:0]   reg_width_q;
  logic [AccW-1:0]     acc_q;
  logic [AccW-1:0]     a_q, a_d;
  logic [AccW-1:0]     b_q, b_d;
  logic [AccW-1:0]     res_q, res_d;
  logic [AccW-1:0]     quo_q, quo_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                a_neg_q, b_neg_q;
  logic                out_valid_q;
  logic [AccW-1:0]     out_value_q;
  logic                in_fire, out_free;

  logic [AddW-1:0]     add_x, add_y, add_sum;
  logic                add_sub;
  logic [AddW-1:0]     sa, sb;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_fire        = in_valid_i && in_ready_o;
  assign out_free       = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;

  assign sa = {{2{a_q[AccW-1]}}, a_q};
  assign sb = {{2{b_q[AccW-1]}}, b_q};

  // Shared adder/subtractor.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      ST_EXEC: begin
        case (mode_q)
          MODE_LOAD: add_y = sb;
          MODE_ADD: begin
            add_x = sa;
            add_y = sb;
          end
          MODE_SUB, MODE_MIN, MODE_MAX: begin
            add_x   = sa;
            add_y   = sb;
            add_sub = 1'b1;
          end
          MODE_DIV, MODE_MOD: begin
            add_y   = {2'b00, a_q};
            add_sub = a_neg_q;
          end
          default: ;
        endcase
      end
      ST_ABSB: begin
        add_y   = {2'b00, b_q};
        add_sub = b_neg_q;
      end
      ST_ITER: begin
        if (mode_q == MODE_MUL) begin
          add_x = {2'b00, res_q};
          add_y = b_q[0] ? {2'b00, a_q} : '0;
        end else begin
          add_x   = {1'b0, res_q, quo_q[AccW-1]};
          add_y   = {2'b00, b_q};
          add_sub = 1'b1;
        end
      end
      ST_FIX: begin
        if (mode_q == MODE_DIV) begin
          add_y   = {2'b00, quo_q};
          add_sub = a_neg_q ^ b_neg_q;
        end else if (a_neg_q && (res_q != '0)) begin
          add_x   = {2'b00, b_q};
          add_y   = {2'b00, res_q};
          add_sub = 1'b1;
        end else begin
          add_x = {2'b00, res_q};
        end
      end
      default: ;
    endcase
    add_sum = add_x + (add_sub ? ~add_y : add_y) + AddW'(add_sub);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    res_d   = res_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          a_d     = acc_q;
          b_d     = operand_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = add_sum[AccW-1:0];
        state_d = ST_OUT;
        case (mode_q)
          MODE_MIN: res_d = add_sum[AddW-1] ? a_q : b_q;
          MODE_MAX: res_d = add_sum[AddW-1] ? b_q : a_q;
          MODE_MUL: begin
            res_d   = '0;
            cnt_d   = '0;
            state_d = ST_ITER;
          end
          MODE_DIV, MODE_MOD: begin
            res_d = '0;
            quo_d = add_sum[AccW-1:0];
            if (b_q != '0) begin
              state_d = ST_ABSB;
            end
          end
          default: ;
        endcase
      end
      ST_ABSB: begin
        b_d     = add_sum[AccW-1:0];
        cnt_d   = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        cnt_d = cnt_q + CntW'(1);
        if (mode_q == MODE_MUL) begin
          res_d = add_sum[AccW-1:0];
          a_d   = a_q << 1;
          b_d   = b_q >> 1;
        end else begin
          if (!add_sum[AddW-1]) begin
            res_d = add_sum[AccW-1:0];
          end else begin
            res_d = {res_q[AccW-2:0], quo_q[AccW-1]};
          end
          quo_d = {quo_q[AccW-2:0], !add_sum[AddW-1]};
        end
        if (cnt_q == CntW'(AccW - 1)) begin
          state_d = (mode_q == MODE_MUL) ? ST_OUT : ST_FIX;
        end
      end
      ST_FIX: begin
        res_d   = add_sum[AccW-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      reg_width_q <= WidthW'(32);
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        reg_width_q <= cfg_wdata_i;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        acc_q       <= wrap_value(res_q, reg_width_q);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    quo_q <= quo_d;
    if (in_fire) begin
      mode_q  <= mode_e'(mode_i);
      a_neg_q <= acc_q[AccW-1];
      b_neg_q <= operand_i[AccW-1];
    end
    if (state_q == ST_OUT && out_free) begin
      out_value_q <= wrap_value(res_q, reg_width_q);
    end
  end

endmodule

`default_nettype wire

[design/wra_checker.sv]
// ----------------------------------------------------------------------------
// Wrapping register ALU port checker
// Port-level checks of the core's handshake sequencing, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module wra_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [31:0] result_value_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // Held result stays until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("result dropped or changed while stalled");

  // One item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready after item accept");

  // No result appears on the cycle right after an accept.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !out_valid_o |=> !out_valid_o)
    else $error("result too early");

  // Becoming ready again means a result was just produced.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("item finished without result");

endmodule

bind wrapping_register_alu_core wra_checker u_wra_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_value_o (result_value_o)
);

`default_nettype wire
